FILE: src/ctp_pkg.sv
// Shared types, constants and helpers for the coordinated-turn prediction block.
// No dependencies; the top level and ctp_sincos refer to this package by scoped names.
`default_nettype none

package ctp_pkg;

    // Wide signed type used for saturating arithmetic
    localparam int SATW = 96;
    typedef logic signed [SATW-1:0] t_wide;
    typedef logic signed [31:0]     t_q32;

    // Angle reduction and CORDIC constants
    localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [32:0] TWO_PI_Q29     = 33'sd3373259426;
    localparam int                 CORDIC_W       = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam int                 ATAN_ENTRIES   = 31;

    // Register index of min_turn_rate
    localparam logic REG_MIN_TURN_RATE = 1'b0;

    // Arctangent of 2^-i in Q30 radians
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837830;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            default: v = 31'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic t_q32 sat32(input t_wide x);
        t_q32 r;
        if (x > t_wide'(64'sh7fff_ffff)) begin
            r = 32'sh7fff_ffff;
        end else if (x < -t_wide'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/coordinated_turn_predict_jacobian.sv
// Coordinated-turn prediction with position Jacobian; top level and config register.
// Depends on ctp_pkg, ctp_delay, ctp_sincos and ctp_div.
//
//   port group        direction  transaction marker
//   start / inputs    in         start high while busy low
//   result / o_valid  out        o_valid high for one cycle, cannot be held off
//   APB config        in/out     psel & penable & pwrite & pready
//
// Each transaction passes through the CORDIC stages and the two bit-per-stage
// dividers. One transaction enters every cycle; busy stays low. Reset is
// synchronous and clears valid bits and the register (min_turn_rate = 7).
// Nothing stalls: every stage advances each cycle.
`default_nettype none

module coordinated_turn_predict_jacobian #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_speed,
    input  logic signed [31:0] i_heading,
    input  logic signed [31:0] i_turn_rate,
    input  logic [30:0]        i_step_time,
    output logic               o_valid,
    output logic signed [31:0] o_pred_x,
    output logic signed [31:0] o_pred_y,
    output logic signed [31:0] o_pred_heading,
    output logic signed [31:0] o_jac_x_speed,
    output logic signed [31:0] o_jac_x_heading,
    output logic signed [31:0] o_jac_x_rate,
    output logic signed [31:0] o_jac_y_speed,
    output logic signed [31:0] o_jac_y_heading,
    output logic signed [31:0] o_jac_y_rate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int F   = FRAC_BITS;
    localparam int SH  = 30 - F;
    localparam int NW1 = 33 + F;
    localparam int NW2 = 64;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic [30:0]        t;
        logic               str;
        logic signed [31:0] ph;
    } t_s2;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic [30:0]        t;
        logic               str;
        logic signed [31:0] ph;
        logic signed [31:0] ca;
        logic signed [31:0] sa;
        logic signed [31:0] sh;
        logic signed [31:0] ch;
        logic signed [63:0] tcb;
        logic signed [63:0] tsb;
        logic [61:0]        ttp;
    } t_s3;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic               str;
        logic signed [31:0] ph;
        logic signed [31:0] jxs;
        logic signed [31:0] jys;
        logic signed [31:0] tsx;
        logic signed [31:0] tcx;
    } t_s5;

    // ---------------------------------------------------------------- config
    logic [16:0] r_mtr;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Hold min_turn_rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtr <= 17'd7;
        end else if (cfg_wr && (paddr[2] == ctp_pkg::REG_MIN_TURN_RATE)) begin
            r_mtr <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == ctp_pkg::REG_MIN_TURN_RATE) ? {15'd0, r_mtr} : 32'd0;

    // ---------------------------------------------------------------- stage 1
    logic               accept;
    logic [31:0]        wabs;
    logic signed [31:0] nw;
    logic               str_in;
    logic               r1_vld;
    logic signed [31:0] r1_px, r1_py, r1_v, r1_h, r1_w;
    logic [30:0]        r1_t;
    logic signed [63:0] r1_wtp;
    logic               r1_str;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign nw     = -i_turn_rate;
    assign wabs   = i_turn_rate[31] ? nw : i_turn_rate;
    assign str_in = (i_turn_rate == 32'sd0) || (wabs < {15'd0, r_mtr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= accept;
    end

    // Take the transaction, form w*T
    always_ff @(posedge i_clk) begin
        r1_px  <= i_pos_x;
        r1_py  <= i_pos_y;
        r1_v   <= i_speed;
        r1_h   <= i_heading;
        r1_w   <= i_turn_rate;
        r1_t   <= i_step_time;
        r1_str <= str_in;
        r1_wtp <= 64'(i_turn_rate) * 64'($signed({1'b0, i_step_time}));
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [63:0] wt, half, hx;
    logic               r2_vld;
    logic signed [63:0] r2_ang [4];
    t_s2                r2_s;

    assign wt   = r1_wtp >>> F;
    assign half = wt >>> 1;
    assign hx   = 64'(r1_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
    end

    // Form the four angles and the predicted heading
    always_ff @(posedge i_clk) begin
        r2_ang[0] <= hx + half;
        r2_ang[1] <= hx + wt;
        r2_ang[2] <= hx;
        r2_ang[3] <= half;
        r2_s.px   <= r1_px;
        r2_s.py   <= r1_py;
        r2_s.v    <= r1_v;
        r2_s.w    <= r1_w;
        r2_s.t    <= r1_t;
        r2_s.str  <= r1_str;
        r2_s.ph   <= ctp_pkg::sat32(ctp_pkg::t_wide'(hx + wt));
    end

    // ---------------------------------------------------------------- sin/cos
    logic               sc_vld;
    logic signed [31:0] sc_sin [4];
    logic signed [31:0] sc_cos [4];
    logic [$bits(t_s2)-1:0] sc_side;
    t_s2                s2o;

    ctp_sincos #(
        .F     (F),
        .ITERS (CORDIC_ITERS),
        .SW    ($bits(t_s2))
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_ang   (r2_ang),
        .i_side  (r2_s),
        .o_vld   (sc_vld),
        .o_sin   (sc_sin),
        .o_cos   (sc_cos),
        .o_side  (sc_side)
    );

    assign s2o = t_s2'(sc_side);

    // ---------------------------------------------------------------- stage 3
    logic signed [32:0]    dsx, dcx;
    logic signed [NW1-1:0] r3_num [3];
    logic                  r3_vld;
    t_s3                   r3_s;
    logic signed [63:0]    tsg;

    assign tsg = $signed({33'd0, s2o.t});
    assign dsx = 33'(sc_sin[2]) - 33'(sc_sin[1]);
    assign dcx = 33'(sc_cos[1]) - 33'(sc_cos[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= sc_vld;
    end

    // Scale the numerators, form the step-time products
    always_ff @(posedge i_clk) begin
        r3_num[0] <= NW1'(sc_sin[3]) <<< (F + 1);
        r3_num[1] <= NW1'(dsx) <<< F;
        r3_num[2] <= NW1'(dcx) <<< F;
        r3_s.px   <= s2o.px;
        r3_s.py   <= s2o.py;
        r3_s.v    <= s2o.v;
        r3_s.w    <= s2o.w;
        r3_s.t    <= s2o.t;
        r3_s.str  <= s2o.str;
        r3_s.ph   <= s2o.ph;
        r3_s.ca   <= sc_cos[0];
        r3_s.sa   <= sc_sin[0];
        r3_s.sh   <= sc_sin[2];
        r3_s.ch   <= sc_cos[2];
        r3_s.tcb  <= tsg * 64'(sc_cos[1]);
        r3_s.tsb  <= tsg * 64'(sc_sin[1]);
        r3_s.ttp  <= 62'(s2o.t) * 62'(s2o.t);
    end

    // ---------------------------------------------------------------- divide by w
    logic                   d1_vld;
    logic signed [NW1:0]    d1_quo [3];
    logic [$bits(t_s3)-1:0] d1_side;
    t_s3                    s3o;

    ctp_div #(
        .L  (3),
        .NW (NW1),
        .SW ($bits(t_s3))
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_s.w),
        .i_side  (r3_s),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    assign s3o = t_s3'(d1_side);

    // ---------------------------------------------------------------- stage 4
    logic signed [NW1:0] q0s, q1s, q2s;
    logic signed [31:0]  dsat, r2s, r3s;
    logic signed [63:0]  tcbs, tsbs;
    logic [61:0]         tts;
    logic                r4_vld;
    logic signed [31:0]  r4_d, r4_gx, r4_gy, r4_hh;
    logic signed [31:0]  r4_px, r4_py, r4_v, r4_w, r4_ph, r4_ca, r4_sa, r4_sh, r4_ch;
    logic                r4_str;

    assign q0s  = d1_quo[0] >>> SH;
    assign q1s  = d1_quo[1] >>> SH;
    assign q2s  = d1_quo[2] >>> SH;
    assign dsat = ctp_pkg::sat32(ctp_pkg::t_wide'(q0s));
    assign r2s  = ctp_pkg::sat32(ctp_pkg::t_wide'(q1s));
    assign r3s  = ctp_pkg::sat32(ctp_pkg::t_wide'(q2s));
    assign tcbs = s3o.tcb >>> 30;
    assign tsbs = s3o.tsb >>> 30;
    assign tts  = s3o.ttp >> (F + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= d1_vld;
    end

    // Pick the straight-line or turning terms
    always_ff @(posedge i_clk) begin
        r4_d   <= s3o.str ? $signed({1'b0, s3o.t}) : dsat;
        r4_gx  <= ctp_pkg::sat32(ctp_pkg::t_wide'(tcbs) + ctp_pkg::t_wide'(r2s));
        r4_gy  <= ctp_pkg::sat32(ctp_pkg::t_wide'(tsbs) + ctp_pkg::t_wide'(r3s));
        r4_hh  <= ctp_pkg::sat32(ctp_pkg::t_wide'({1'b0, tts}));
        r4_px  <= s3o.px;
        r4_py  <= s3o.py;
        r4_v   <= s3o.v;
        r4_w   <= s3o.w;
        r4_ph  <= s3o.ph;
        r4_ca  <= s3o.ca;
        r4_sa  <= s3o.sa;
        r4_sh  <= s3o.sh;
        r4_ch  <= s3o.ch;
        r4_str <= s3o.str;
    end

    // ---------------------------------------------------------------- stage 5
    logic                r5_vld;
    logic signed [63:0]  r5_pdc, r5_pds, r5_phs, r5_phc;
    logic signed [NW2-1:0] r5_num [2];
    logic signed [31:0]  r5_px, r5_py, r5_v, r5_w, r5_ph;
    logic                r5_str;
    t_s5                 s5i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else          r5_vld <= r4_vld;
    end

    // Multiply out the speed and rate terms
    always_ff @(posedge i_clk) begin
        r5_pdc    <= 64'(r4_d) * 64'(r4_ca);
        r5_pds    <= 64'(r4_d) * 64'(r4_sa);
        r5_phs    <= 64'(r4_hh) * 64'(r4_sh);
        r5_phc    <= 64'(r4_hh) * 64'(r4_ch);
        r5_num[0] <= 64'(r4_v) * 64'(r4_gx);
        r5_num[1] <= 64'(r4_v) * 64'(r4_gy);
        r5_px     <= r4_px;
        r5_py     <= r4_py;
        r5_v      <= r4_v;
        r5_w      <= r4_w;
        r5_ph     <= r4_ph;
        r5_str    <= r4_str;
    end

    always_comb begin
        s5i.px  = r5_px;
        s5i.py  = r5_py;
        s5i.v   = r5_v;
        s5i.str = r5_str;
        s5i.ph  = r5_ph;
        s5i.jxs = ctp_pkg::sat32(ctp_pkg::t_wide'(r5_pdc >>> 30));
        s5i.jys = ctp_pkg::sat32(ctp_pkg::t_wide'(r5_pds >>> 30));
        s5i.tsx = ctp_pkg::sat32(ctp_pkg::t_wide'(r5_phs >>> 30));
        s5i.tcx = ctp_pkg::sat32(ctp_pkg::t_wide'(r5_phc >>> 30));
    end

    // ---------------------------------------------------------------- rate divide
    logic                   d2_vld;
    logic signed [NW2:0]    d2_quo [2];
    logic [$bits(t_s5)-1:0] d2_side;
    t_s5                    s5o;

    ctp_div #(
        .L  (2),
        .NW (NW2),
        .SW ($bits(t_s5))
    ) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_w),
        .i_side  (s5i),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign s5o = t_s5'(d2_side);

    // ---------------------------------------------------------------- stage 6
    logic               r6_vld;
    logic signed [63:0] r6_pdx, r6_pdy, r6_psx, r6_pcx;
    logic signed [31:0] r6_jxrd, r6_jyrd, r6_px, r6_py, r6_ph, r6_jxs, r6_jys;
    logic               r6_str;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else          r6_vld <= d2_vld;
    end

    // Scale the Jacobian speed entries by v
    always_ff @(posedge i_clk) begin
        r6_pdx  <= 64'(s5o.v) * 64'(s5o.jxs);
        r6_pdy  <= 64'(s5o.v) * 64'(s5o.jys);
        r6_psx  <= 64'(s5o.v) * 64'(s5o.tsx);
        r6_pcx  <= 64'(s5o.v) * 64'(s5o.tcx);
        r6_jxrd <= ctp_pkg::sat32(ctp_pkg::t_wide'(d2_quo[0]));
        r6_jyrd <= ctp_pkg::sat32(ctp_pkg::t_wide'(d2_quo[1]));
        r6_px   <= s5o.px;
        r6_py   <= s5o.py;
        r6_ph   <= s5o.ph;
        r6_jxs  <= s5o.jxs;
        r6_jys  <= s5o.jys;
        r6_str  <= s5o.str;
    end

    // ---------------------------------------------------------------- stage 7
    logic signed [63:0] dx, dy, sxs, cxs;
    logic               r7_vld;
    logic signed [31:0] r7_px, r7_py, r7_ph, r7_jxs, r7_jxh, r7_jxr;
    logic signed [31:0] r7_jys, r7_jyh, r7_jyr;

    assign dx  = r6_pdx >>> F;
    assign dy  = r6_pdy >>> F;
    assign sxs = r6_psx >>> F;
    assign cxs = r6_pcx >>> F;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else          r7_vld <= r6_vld;
    end

    // Final sums and the result register
    always_ff @(posedge i_clk) begin
        r7_px  <= ctp_pkg::sat32(ctp_pkg::t_wide'(r6_px) + ctp_pkg::t_wide'(dx));
        r7_py  <= ctp_pkg::sat32(ctp_pkg::t_wide'(r6_py) + ctp_pkg::t_wide'(dy));
        r7_ph  <= r6_ph;
        r7_jxs <= r6_jxs;
        r7_jxh <= ctp_pkg::sat32(-ctp_pkg::t_wide'(dy));
        r7_jxr <= r6_str ? ctp_pkg::sat32(-ctp_pkg::t_wide'(sxs)) : r6_jxrd;
        r7_jys <= r6_jys;
        r7_jyh <= ctp_pkg::sat32(ctp_pkg::t_wide'(dx));
        r7_jyr <= r6_str ? ctp_pkg::sat32(ctp_pkg::t_wide'(cxs)) : r6_jyrd;
    end

    assign o_valid         = r7_vld;
    assign o_pred_x        = r7_px;
    assign o_pred_y        = r7_py;
    assign o_pred_heading  = r7_ph;
    assign o_jac_x_speed   = r7_jxs;
    assign o_jac_x_heading = r7_jxh;
    assign o_jac_x_rate    = r7_jxr;
    assign o_jac_y_speed   = r7_jys;
    assign o_jac_y_heading = r7_jyh;
    assign o_jac_y_rate    = r7_jyr;

endmodule

`default_nettype wire

FILE: src/ctp_delay.sv
// Fixed-latency delay line for a valid bit and a side payload.
// Depends on nothing.
`default_nettype none

module ctp_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic         r_vld  [N];
    logic [W-1:0] r_data [N];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < N; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r_data[0] <= i_data;
        for (int k = 1; k < N; k++) r_data[k] <= r_data[k-1];
    end

    assign o_vld  = r_vld[N-1];
    assign o_data = r_data[N-1];

endmodule

`default_nettype wire

FILE: src/ctp_sincos.sv
// Four-lane pipelined sine/cosine: phase reduction, quadrant split, CORDIC.
// Depends on ctp_pkg and ctp_delay.
`default_nettype none

module ctp_sincos #(
    parameter int F     = 16,
    parameter int ITERS = 20,
    parameter int SW    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic signed [63:0]  i_ang [4],
    input  logic [SW-1:0]       i_side,
    output logic                o_vld,
    output logic signed [31:0]  o_sin [4],
    output logic signed [31:0]  o_cos [4],
    output logic [SW-1:0]       o_side
);

    localparam int LW  = F + 32;
    localparam int LH  = LW / 2;
    localparam int HW  = LW - LH;
    localparam int NIT = (ITERS < ctp_pkg::ATAN_ENTRIES) ? ITERS : ctp_pkg::ATAN_ENTRIES;
    localparam int CW  = ctp_pkg::CORDIC_W;
    localparam int LAT = NIT + 4;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [LH-1:0]             lo;
        logic [HW-1:0]             hi;
        logic [LH+29:0]            lprod;
        logic [HW+29:0]            hprod;
        logic [LH+29:0]            r_lp;
        logic [HW-1:0]             r_hp;
        logic [LW-1:0]             sum;
        logic [31:0]               phase;
        logic [31:0]               pq;
        logic [1:0]                q;
        logic [31:0]               rem;
        logic [1:0]                r_q;
        logic signed [31:0]        r_rem;
        logic signed [64:0]        r_zp;
        logic [1:0]                r_qc;
        logic signed [CW-1:0]      x0;
        logic signed [CW-1:0]      y0;
        logic signed [CW-1:0]      z0;
        logic signed [CW-1:0]      r_x [NIT];
        logic signed [CW-1:0]      r_y [NIT];
        logic signed [CW-1:0]      r_z [NIT];
        logic [1:0]                r_qk [NIT];
        logic signed [CW-1:0]      xl;
        logic signed [CW-1:0]      yl;
        logic signed [CW-1:0]      nxl;
        logic signed [CW-1:0]      nyl;
        logic signed [31:0]        r_sin;
        logic signed [31:0]        r_cos;

        // Phase in turns: split the angle so each multiply stays narrow
        assign lo    = i_ang[g][LH-1:0];
        assign hi    = i_ang[g][LW-1:LH];
        assign lprod = (LH+30)'(lo) * (LH+30)'(ctp_pkg::INV_TWO_PI_Q32);
        assign hprod = (HW+30)'(hi) * (HW+30)'(ctp_pkg::INV_TWO_PI_Q32);

        always_ff @(posedge i_clk) begin
            r_lp <= lprod;
            r_hp <= hprod[HW-1:0];
        end

        // Combine partial products, split off the quadrant
        assign sum   = r_lp[LW-1:0] + {r_hp, {LH{1'b0}}};
        assign phase = sum[LW-1:F];
        assign pq    = phase + 32'h2000_0000;
        assign q     = pq[31:30];
        assign rem   = phase - {q, 30'd0};

        always_ff @(posedge i_clk) begin
            r_q   <= q;
            r_rem <= $signed(rem);
        end

        // Turn the remainder into Q30 radians
        always_ff @(posedge i_clk) begin
            r_zp <= 65'(r_rem) * 65'(ctp_pkg::TWO_PI_Q29);
            r_qc <= r_q;
        end

        assign x0 = ctp_pkg::CORDIC_GAIN_Q30;
        assign y0 = '0;
        assign z0 = CW'($signed(r_zp[62:31]));

        // One CORDIC rotation per stage
        for (genvar k = 0; k < NIT; k++) begin : g_it
            logic signed [CW-1:0] xi;
            logic signed [CW-1:0] yi;
            logic signed [CW-1:0] zi;
            logic [1:0]           qi;
            logic signed [CW-1:0] at;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;

            if (k == 0) begin : g_first
                assign xi = x0;
                assign yi = y0;
                assign zi = z0;
                assign qi = r_qc;
            end else begin : g_next
                assign xi = r_x[k-1];
                assign yi = r_y[k-1];
                assign zi = r_z[k-1];
                assign qi = r_qk[k-1];
            end

            assign at = CW'({1'b0, ctp_pkg::atan_q30(5'(k))});
            assign xs = xi >>> k;
            assign ys = yi >>> k;

            always_ff @(posedge i_clk) begin
                if (!zi[CW-1]) begin
                    r_x[k] <= xi - ys;
                    r_y[k] <= yi + xs;
                    r_z[k] <= zi - at;
                end else begin
                    r_x[k] <= xi + ys;
                    r_y[k] <= yi - xs;
                    r_z[k] <= zi + at;
                end
                r_qk[k] <= qi;
            end
        end

        // Rotate back by the quadrant
        assign xl  = r_x[NIT-1];
        assign yl  = r_y[NIT-1];
        assign nxl = -xl;
        assign nyl = -yl;

        always_ff @(posedge i_clk) begin
            case (r_qk[NIT-1])
                2'd0: begin
                    r_cos <= xl[31:0];
                    r_sin <= yl[31:0];
                end
                2'd1: begin
                    r_cos <= nyl[31:0];
                    r_sin <= xl[31:0];
                end
                2'd2: begin
                    r_cos <= nxl[31:0];
                    r_sin <= nyl[31:0];
                end
                default: begin
                    r_cos <= yl[31:0];
                    r_sin <= nxl[31:0];
                end
            endcase
        end

        assign o_sin[g] = r_sin;
        assign o_cos[g] = r_cos;
    end

    // Carry the valid bit and side payload alongside the lanes
    ctp_delay #(
        .W (SW),
        .N (LAT)
    ) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_data  (i_side),
        .o_vld   (o_vld),
        .o_data  (o_side)
    );

endmodule

`default_nettype wire

FILE: src/ctp_div.sv
// Pipelined signed divider, one quotient bit per stage, lanes share a 32-bit divisor.
// Quotient truncates toward zero. Depends on ctp_delay.
`default_nettype none

module ctp_div #(
    parameter int L  = 1,
    parameter int NW = 48,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic signed [NW-1:0] i_num [L],
    input  logic signed [31:0]  i_den,
    input  logic [SW-1:0]       i_side,
    output logic                o_vld,
    output logic signed [NW:0]  o_quo [L],
    output logic [SW-1:0]       o_side
);

    localparam int AW  = NW + 33;
    localparam int LAT = NW + 2;

    logic [31:0]   r_dm  [NW];
    logic [31:0]   dmag;
    logic signed [31:0] nden;

    // Divisor magnitude, then hold it down the pipe
    assign nden = -i_den;
    assign dmag = i_den[31] ? nden : i_den;

    always_ff @(posedge i_clk) begin
        r_dm[0] <= dmag;
        for (int k = 1; k < NW; k++) r_dm[k] <= r_dm[k-1];
    end

    for (genvar g = 0; g < L; g++) begin : g_lane
        logic [AW-1:0]       r_acc [NW+1];
        logic                r_neg [NW+1];
        logic signed [NW-1:0] nnum;
        logic [NW-1:0]       nmag;
        logic signed [NW:0]  mag;
        logic signed [NW:0]  r_quo;

        assign nnum = -i_num[g];
        assign nmag = i_num[g][NW-1] ? nnum : i_num[g];

        always_ff @(posedge i_clk) begin
            r_acc[0] <= {33'd0, nmag};
            r_neg[0] <= i_num[g][NW-1] ^ i_den[31];
        end

        // Restoring step: shift in a dividend bit, subtract if it fits
        for (genvar k = 1; k <= NW; k++) begin : g_step
            logic [32:0] trial;
            logic [32:0] diff;
            logic        fits;

            assign trial = {r_acc[k-1][NW+31:NW], r_acc[k-1][NW-1]};
            assign diff  = trial - {1'b0, r_dm[k-1]};
            assign fits  = (trial >= {1'b0, r_dm[k-1]});

            always_ff @(posedge i_clk) begin
                r_acc[k] <= {fits ? diff : trial, r_acc[k-1][NW-2:0], fits};
                r_neg[k] <= r_neg[k-1];
            end
        end

        // Apply the sign
        assign mag = $signed({1'b0, r_acc[NW][NW-1:0]});

        always_ff @(posedge i_clk) begin
            r_quo <= r_neg[NW] ? -mag : mag;
        end

        assign o_quo[g] = r_quo;
    end

    ctp_delay #(
        .W (SW),
        .N (LAT)
    ) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_data  (i_side),
        .o_vld   (o_vld),
        .o_data  (o_side)
    );

endmodule

`default_nettype wire
